/* sv/esc_pkg.sv */
// ----------------------------------------------------------------------------
// esc_pkg
// Shared constants for the seconds-to-calendar converter: divisors, scaled
// reciprocals for the constant divisions, stage count and the cumulative
// day offsets of the four-year cycle.
// ----------------------------------------------------------------------------
package esc_pkg;

  localparam int STAGES = 10;

  localparam int EPOCH_W = 32;
  localparam int MINS_W  = 27;
  localparam int HOURS_W = 21;
  localparam int DAYS_W  = 16;
  localparam int DOFF_W  = 11;
  localparam int CYC_W   = 6;

  localparam int DATA_W_IN  = 32;
  localparam int DATA_W_OUT = 40;

  localparam logic [5:0]  SEC_PER_MIN    = 6'd60;
  localparam logic [5:0]  MIN_PER_HOUR   = 6'd60;
  localparam logic [4:0]  HOUR_PER_DAY   = 5'd24;
  localparam logic [10:0] DAYS_PER_CYCLE = 11'(365 * 4 + 1);

  localparam logic [26:0] RCP_SEC  = 27'((64'd1 << EPOCH_W) / 64'd60);
  localparam logic [21:0] RCP_MIN  = 22'((64'd1 << MINS_W) / 64'd60);
  localparam logic [16:0] RCP_HOUR = 17'((64'd1 << HOURS_W) / 64'd24);
  localparam logic [5:0]  RCP_DAY  = 6'((64'd1 << DAYS_W) / 64'd1461);

  localparam logic [10:0] MONTH_START [4][12] = '{
    '{11'd0,    11'd31,   11'd60,   11'd91,   11'd121,  11'd152,
      11'd182,  11'd213,  11'd244,  11'd274,  11'd305,  11'd335},
    '{11'd366,  11'd397,  11'd425,  11'd456,  11'd486,  11'd517,
      11'd547,  11'd578,  11'd609,  11'd639,  11'd670,  11'd700},
    '{11'd731,  11'd762,  11'd790,  11'd821,  11'd851,  11'd882,
      11'd912,  11'd943,  11'd974,  11'd1004, 11'd1035, 11'd1065},
    '{11'd1096, 11'd1127, 11'd1155, 11'd1186, 11'd1216, 11'd1247,
      11'd1277, 11'd1308, 11'd1339, 11'd1369, 11'd1400, 11'd1430}
  };

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } hms_t;

endpackage

/* sv/epoch_seconds_to_calendar_unit.sv */
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_unit
// Converts a 32-bit count of seconds since 2000-01-01 00:00:00 into second,
// minute, hour, day of month, month and years since 2000 (leap every 4 years).
//
//   channel | dir | tdata fields (lsb first)
//   --------+-----+----------------------------------------------------------
//   in_     | in  | epoch_seconds[31:0]
//   out_    | out | second[5:0] minute[11:6] hour[16:12] day_of_month[21:17]
//           |     | month[25:22] year_offset[33:26], zero pad [39:34]
//
// One transaction per cycle enters and leaves while out_tready is held high.
// Each of the four constant divisions takes two stages (reciprocal multiply,
// then remainder and one-step correction); year and month search take two.
// Each stage loads when it is empty or its successor loads, so bubbles close
// up; with a result waiting at the output, input is taken if a stage is empty.
// rst_n clears the stage valid bits only.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [esc_pkg::DATA_W_IN-1:0]   in_tdata,   // epoch_seconds
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [esc_pkg::DATA_W_OUT-1:0]  out_tdata   // second, minute, hour,
                                                      // day_of_month, month,
                                                      // year_offset, pad
);
  import esc_pkg::*;

  logic [STAGES-1:0] v_r, v_nxt, rdy;

  logic [EPOCH_W-1:0] x0_r;
  logic [58:0]        p0_r;

  hms_t               hms1_r, hms1_nxt;
  logic [MINS_W-1:0]  m1_r, m1_nxt;

  hms_t               hms2_r;
  logic [MINS_W-1:0]  x2_r;
  logic [48:0]        p2_r;

  hms_t               hms3_r, hms3_nxt;
  logic [HOURS_W-1:0] h3_r, h3_nxt;

  hms_t               hms4_r;
  logic [HOURS_W-1:0] x4_r;
  logic [37:0]        p4_r;

  hms_t               hms5_r, hms5_nxt;
  logic [DAYS_W-1:0]  dy5_r, dy5_nxt;

  hms_t               hms6_r;
  logic [DAYS_W-1:0]  x6_r;
  logic [21:0]        p6_r;

  hms_t               hms7_r;
  logic [CYC_W-1:0]   cyc7_r, cyc7_nxt;
  logic [DOFF_W-1:0]  d7_r, d7_nxt;

  hms_t               hms8_r;
  logic [1:0]         yr8_r, yr8_nxt;
  logic [7:0]         yoff8_r;
  logic [DOFF_W-1:0]  d8_r;

  hms_t               hms9_r;
  logic [7:0]         yoff9_r;
  logic [3:0]         mon9_r, mon9_nxt;
  logic [4:0]         dom9_r, dom9_nxt;

  logic [26:0]        q1;
  logic [EPOCH_W-1:0] r1w;
  logic [6:0]         r1;
  logic [21:0]        q3;
  logic [MINS_W-1:0]  r3w;
  logic [6:0]         r3;
  logic [16:0]        q5;
  logic [HOURS_W-1:0] r5w;
  logic [5:0]         r5;
  logic [5:0]         q7;
  logic [DAYS_W-1:0]  r7w;
  logic [11:0]        r7;
  logic [3:0]         mo9;

  // handshake and valid chain
  always_comb begin
    rdy[STAGES-1] = !v_r[STAGES-1] || out_tready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
    v_nxt[0] = rdy[0] ? in_tvalid : v_r[0];
    for (int i = 1; i < STAGES; i++) begin
      v_nxt[i] = rdy[i] ? v_r[i-1] : v_r[i];
    end
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = v_r[STAGES-1];
  assign out_tdata  = {6'd0, yoff9_r, mon9_r, dom9_r,
                       hms9_r.hour, hms9_r.minute, hms9_r.second};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // seconds
  always_comb begin
    q1  = p0_r[58:32];
    r1w = x0_r - (32'(q1) * 32'(SEC_PER_MIN));
    r1  = r1w[6:0];
    hms1_nxt = '0;
    if (r1 >= 7'(SEC_PER_MIN)) begin
      hms1_nxt.second = 6'(r1 - 7'(SEC_PER_MIN));
      m1_nxt          = q1 + 27'd1;
    end else begin
      hms1_nxt.second = r1[5:0];
      m1_nxt          = q1;
    end
  end

  // minutes
  always_comb begin
    q3  = p2_r[48:27];
    r3w = x2_r - (27'(q3) * 27'(MIN_PER_HOUR));
    r3  = r3w[6:0];
    hms3_nxt = hms2_r;
    if (r3 >= 7'(MIN_PER_HOUR)) begin
      hms3_nxt.minute = 6'(r3 - 7'(MIN_PER_HOUR));
      h3_nxt          = HOURS_W'(q3 + 22'd1);
    end else begin
      hms3_nxt.minute = r3[5:0];
      h3_nxt          = HOURS_W'(q3);
    end
  end

  // hours
  always_comb begin
    q5  = p4_r[37:21];
    r5w = x4_r - (21'(q5) * 21'(HOUR_PER_DAY));
    r5  = r5w[5:0];
    hms5_nxt = hms4_r;
    if (r5 >= 6'(HOUR_PER_DAY)) begin
      hms5_nxt.hour = 5'(r5 - 6'(HOUR_PER_DAY));
      dy5_nxt       = DAYS_W'(q5 + 17'd1);
    end else begin
      hms5_nxt.hour = r5[4:0];
      dy5_nxt       = DAYS_W'(q5);
    end
  end

  // four-year cycles
  always_comb begin
    q7  = p6_r[21:16];
    r7w = x6_r - (16'(q7) * 16'(DAYS_PER_CYCLE));
    r7  = r7w[11:0];
    if (r7 >= 12'(DAYS_PER_CYCLE)) begin
      d7_nxt   = 11'(r7 - 12'(DAYS_PER_CYCLE));
      cyc7_nxt = q7 + 6'd1;
    end else begin
      d7_nxt   = r7[10:0];
      cyc7_nxt = q7;
    end
  end

  // year within cycle
  always_comb begin
    if (d7_r >= MONTH_START[3][0]) begin
      yr8_nxt = 2'd3;
    end else if (d7_r >= MONTH_START[2][0]) begin
      yr8_nxt = 2'd2;
    end else if (d7_r >= MONTH_START[1][0]) begin
      yr8_nxt = 2'd1;
    end else begin
      yr8_nxt = 2'd0;
    end
  end

  // month and day
  always_comb begin
    mo9 = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (d8_r >= MONTH_START[yr8_r][4'(i)]) begin
        mo9 = 4'(i);
      end
    end
    mon9_nxt = mo9 + 4'd1;
    dom9_nxt = 5'(d8_r - MONTH_START[yr8_r][mo9] + 11'd1);
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      x0_r <= in_tdata[EPOCH_W-1:0];
      p0_r <= 59'(in_tdata[EPOCH_W-1:0]) * 59'(RCP_SEC);
    end
    if (rdy[1]) begin
      hms1_r <= hms1_nxt;
      m1_r   <= m1_nxt;
    end
    if (rdy[2]) begin
      hms2_r <= hms1_r;
      x2_r   <= m1_r;
      p2_r   <= 49'(m1_r) * 49'(RCP_MIN);
    end
    if (rdy[3]) begin
      hms3_r <= hms3_nxt;
      h3_r   <= h3_nxt;
    end
    if (rdy[4]) begin
      hms4_r <= hms3_r;
      x4_r   <= h3_r;
      p4_r   <= 38'(h3_r) * 38'(RCP_HOUR);
    end
    if (rdy[5]) begin
      hms5_r <= hms5_nxt;
      dy5_r  <= dy5_nxt;
    end
    if (rdy[6]) begin
      hms6_r <= hms5_r;
      x6_r   <= dy5_r;
      p6_r   <= 22'(dy5_r) * 22'(RCP_DAY);
    end
    if (rdy[7]) begin
      hms7_r <= hms6_r;
      cyc7_r <= cyc7_nxt;
      d7_r   <= d7_nxt;
    end
    if (rdy[8]) begin
      hms8_r  <= hms7_r;
      yr8_r   <= yr8_nxt;
      yoff8_r <= {cyc7_r, yr8_nxt};
      d8_r    <= d7_r - MONTH_START[yr8_nxt][0] + MONTH_START[yr8_nxt][0];
    end
    if (rdy[9]) begin
      hms9_r  <= hms8_r;
      yoff9_r <= yoff8_r;
      mon9_r  <= mon9_nxt;
      dom9_r  <= dom9_nxt;
    end
  end

  a_accept_fills_first : assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v_r[0])
    else $error("accepted transaction not captured in first stage");

  a_sec_range : assert property (@(posedge clk) disable iff (!rst_n)
    v_r[1] |-> hms1_r.second < SEC_PER_MIN)
    else $error("second correction out of range");

  a_min_range : assert property (@(posedge clk) disable iff (!rst_n)
    v_r[3] |-> hms3_r.minute < MIN_PER_HOUR)
    else $error("minute correction out of range");

  a_day_range : assert property (@(posedge clk) disable iff (!rst_n)
    v_r[7] |-> (d7_r < DAYS_PER_CYCLE) && (hms7_r.hour < HOUR_PER_DAY))
    else $error("day or hour correction out of range");

  a_out_date : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (mon9_r != 4'd0) && (mon9_r <= 4'd12) && (dom9_r != 5'd0))
    else $error("month or day of month out of range");

endmodule
